/* rtl/core/sha256_stream_hasher_macros.svh */
// Assertion macros shared by the SHA-256 stream hasher RTL.
// No dependencies; included by the files that carry concurrent checks.
`ifndef SHA256_STREAM_HASHER_MACROS_SVH
`define SHA256_STREAM_HASHER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SHA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("sha256 check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SHA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("sha256 check failed");

`endif

/* rtl/core/sha_pkg.sv */
// Shared types and constants for the SHA-256 stream hasher.
// No dependencies; imported by sha_blkmem, sha_comp and sha256_stream_hasher.
package sha_pkg;

	// Block buffer geometry: sixteen 32-bit big-endian words.
	localparam int unsigned BLK_WORDS = 16;
	localparam int unsigned ADDR_W    = $clog2(BLK_WORDS);

	localparam logic [31:0] PAD_WORD   = 32'h8000_0000;
	localparam logic [63:0] BLOCK_BITS = 64'd512;

	typedef logic [7:0][31:0] hash_t;

	// Controller states.
	typedef enum logic [2:0] {
		S_IN,
		S_PAD1,
		S_ZERO,
		S_LEN,
		S_COMP,
		S_OUT
	} ctl_state_t;

	// Compression engine states.
	typedef enum logic [1:0] {
		C_IDLE,
		C_LOAD,
		C_ROUND,
		C_FOLD
	} comp_state_t;

	// Block buffer write port, one byte enable per lane (bit 3 is the first byte).
	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [3:0]        mask;
		logic [31:0]       data;
	} mem_wr_t;

	typedef struct packed {
		logic start;
		logic reinit;
	} comp_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} comp_sts_t;

	// Initial hash value, word 0 in the lowest slot.
	localparam hash_t HASH_INIT = {
		32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
		32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
	};

	// Round constants.
	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

endpackage

/* rtl/core/sha_blkmem.sv */
// Block buffer: 16 x 32-bit synchronous RAM with byte-lane writes.
// Depends on sha_pkg for the write port type and address width.
module sha_blkmem (
	input  logic                       clk,
	input  sha_pkg::mem_wr_t           wr,
	input  logic [sha_pkg::ADDR_W-1:0] rd_addr,
	output logic [31:0]                rd_data
);
	import sha_pkg::*;

	logic [31:0] mem_q [BLK_WORDS];
	logic [31:0] rd_q;

	// Byte-masked write and registered read.
	always_ff @(posedge clk) begin
		if (wr.en) begin
			for (int i = 0; i < 4; i++) begin
				if (wr.mask[i]) begin
					mem_q[wr.addr][8*i +: 8] <= wr.data[8*i +: 8];
				end
			end
		end
		rd_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_q;

endmodule

/* rtl/core/sha_comp.sv */
// SHA-256 compression engine: one round per cycle over the block buffer.
// Depends on sha_pkg; reads sha_blkmem through its registered read port.
module sha_comp (
	input  logic                       clk,
	input  logic                       arst_n,
	input  sha_pkg::comp_ctl_t         ctl,
	output logic [sha_pkg::ADDR_W-1:0] rd_addr,
	input  logic [31:0]                rd_data,
	output sha_pkg::comp_sts_t         sts,
	output sha_pkg::hash_t             hash
);
	import sha_pkg::*;

	comp_state_t cst_q, cst_n;
	logic [5:0]  rnd_q;
	hash_t       hash_q;
	hash_t       v_q;
	logic [31:0] w_q [BLK_WORDS];
	logic [31:0] w_t, t1, t2, ch, maj;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] bsig0(input logic [31:0] x);
		return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic logic [31:0] bsig1(input logic [31:0] x);
		return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic logic [31:0] ssig0(input logic [31:0] x);
		return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] ssig1(input logic [31:0] x);
		return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	// Next state.
	always_comb begin
		cst_n = cst_q;
		case (cst_q)
			C_IDLE: begin
				if (ctl.start) begin
					cst_n = C_LOAD;
				end
			end
			C_LOAD: cst_n = C_ROUND;
			C_ROUND: begin
				if (rnd_q == 6'd63) begin
					cst_n = C_FOLD;
				end
			end
			C_FOLD: cst_n = C_IDLE;
			default: cst_n = C_IDLE;
		endcase
	end

	// Status and buffer read address; the word for round r+1 is fetched during round r.
	always_comb begin
		sts.busy = (cst_q != C_IDLE);
		sts.done = (cst_q == C_FOLD);
		case (cst_q)
			C_ROUND: rd_addr = rnd_q[ADDR_W-1:0] + ADDR_W'(1);
			default: rd_addr = '0;
		endcase
	end

	// Message schedule word and round functions.
	always_comb begin
		if (rnd_q[5:4] == 2'b00) begin
			w_t = rd_data;
		end else begin
			w_t = ssig1(w_q[14]) + w_q[9] + ssig0(w_q[1]) + w_q[0];
		end
		ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t1  = v_q[7] + bsig1(v_q[4]) + ch + ROUND_K[rnd_q] + w_t;
		t2  = bsig0(v_q[0]) + maj;
	end

	// Control state and chaining value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cst_q  <= C_IDLE;
			rnd_q  <= '0;
			hash_q <= HASH_INIT;
		end else begin
			cst_q <= cst_n;
			if (cst_q == C_LOAD) begin
				rnd_q <= '0;
			end else if (cst_q == C_ROUND) begin
				rnd_q <= rnd_q + 6'd1;
			end
			if (ctl.reinit) begin
				hash_q <= HASH_INIT;
			end else if (cst_q == C_FOLD) begin
				for (int i = 0; i < 8; i++) begin
					hash_q[i] <= hash_q[i] + v_q[i];
				end
			end
		end
	end

	// Working variables and the sixteen-word schedule window.
	always_ff @(posedge clk) begin
		if (cst_q == C_IDLE && ctl.start) begin
			v_q <= hash_q;
		end else if (cst_q == C_ROUND) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
			for (int i = 0; i < BLK_WORDS - 1; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[BLK_WORDS-1] <= w_t;
		end
	end

	assign hash = hash_q;

endmodule

/* rtl/core/sha256_stream_hasher.sv */
// A byte beat is taken each cycle while the controller is in its input state; the 64th
// byte of a block stalls input while the engine fetches, runs the rounds at one per cycle and folds.
// End of message: padding writes plus one or two compressions, then eight digest beats;
// input is held off until the last digest beat is taken.
// Reset is asynchronous, active low: the hash returns to its initial value and the
// counts clear; the block buffer RAM is not cleared.
`include "sha256_stream_hasher_macros.svh"

// Top level: byte intake, padding sequencer and digest output around the engine.
// Depends on sha_pkg, sha_blkmem and sha_comp.
module sha256_stream_hasher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tuser,   // [0] byte_valid
	input  logic        s_tlast,   // end_of_message
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, rest zero
	output logic        m_tlast    // last_word
);
	import sha_pkg::*;

	ctl_state_t        st_q, st_n, ret_q, ret_n;
	logic [5:0]        fill_q;
	logic [63:0]       bits_q;
	logic [ADDR_W-1:0] widx_q;
	logic [2:0]        oidx_q;
	logic              in_acc, byte_in, full, out_acc;
	mem_wr_t           wr;
	comp_ctl_t         ctl;
	comp_sts_t         sts;
	logic [ADDR_W-1:0] rd_addr;
	logic [31:0]       rd_data;
	hash_t             hash;

	sha_blkmem u_blkmem (
		.clk     (clk),
		.wr      (wr),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	sha_comp u_comp (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.sts     (sts),
		.hash    (hash)
	);

	assign in_acc  = s_tvalid && s_tready;
	assign byte_in = in_acc && s_tuser;
	assign full    = byte_in && (fill_q == 6'd63);
	assign out_acc = m_tvalid && m_tready;

	// Next state and where to go once a compression finishes.
	always_comb begin
		st_n  = st_q;
		ret_n = S_IN;
		case (st_q)
			S_IN: begin
				if (full) begin
					st_n  = S_COMP;
					ret_n = s_tlast ? S_PAD1 : S_IN;
				end else if (in_acc && s_tlast) begin
					st_n = S_PAD1;
				end
			end
			S_PAD1: begin
				if (fill_q[5:2] == 4'd15) begin
					st_n  = S_COMP;
					ret_n = S_ZERO;
				end else if (fill_q[5:2] == 4'd13) begin
					st_n = S_LEN;
				end else begin
					st_n = S_ZERO;
				end
			end
			S_ZERO: begin
				if (widx_q == ADDR_W'(15)) begin
					st_n  = S_COMP;
					ret_n = S_ZERO;
				end else if (widx_q == ADDR_W'(13)) begin
					st_n = S_LEN;
				end
			end
			S_LEN: begin
				if (widx_q == ADDR_W'(15)) begin
					st_n  = S_COMP;
					ret_n = S_OUT;
				end
			end
			S_COMP: begin
				if (sts.done) begin
					st_n = ret_q;
				end
			end
			S_OUT: begin
				if (out_acc && m_tlast) begin
					st_n = S_IN;
				end
			end
			default: st_n = S_IN;
		endcase
	end

	// Handshakes, buffer writes and engine control.
	always_comb begin
		s_tready = (st_q == S_IN);
		m_tvalid = (st_q == S_OUT);
		m_tdata  = {5'd0, oidx_q, hash[oidx_q]};
		m_tlast  = (oidx_q == 3'd7);
		wr       = '0;
		case (st_q)
			S_IN: begin
				wr.en   = byte_in;
				wr.addr = fill_q[5:2];
				wr.mask = 4'b1000 >> fill_q[1:0];
				wr.data = {4{s_tdata}};
			end
			S_PAD1: begin
				// Marker byte after the last message byte, zeros in the rest of the word.
				wr.en   = 1'b1;
				wr.addr = fill_q[5:2];
				wr.mask = 4'b1111 >> fill_q[1:0];
				wr.data = PAD_WORD >> {fill_q[1:0], 3'b000};
			end
			S_ZERO: begin
				wr.en   = 1'b1;
				wr.addr = widx_q;
				wr.mask = 4'b1111;
				wr.data = '0;
			end
			S_LEN: begin
				wr.en   = 1'b1;
				wr.addr = widx_q;
				wr.mask = 4'b1111;
				wr.data = widx_q[0] ? bits_q[31:0] : bits_q[63:32];
			end
			default: wr = '0;
		endcase
		ctl.start  = (st_q != S_COMP) && (st_n == S_COMP);
		ctl.reinit = (st_q == S_OUT) && out_acc && m_tlast;
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= S_IN;
			ret_q  <= S_IN;
			fill_q <= '0;
			bits_q <= '0;
			widx_q <= '0;
			oidx_q <= '0;
		end else begin
			st_q <= st_n;
			if (ctl.start) begin
				ret_q <= ret_n;
			end
			case (st_q)
				S_IN: begin
					if (byte_in) begin
						fill_q <= fill_q + 6'd1;
					end
					if (full) begin
						bits_q <= bits_q + BLOCK_BITS;
					end
				end
				S_PAD1: begin
					// Fold the partial block into the length, then restart the fill.
					bits_q <= bits_q + {55'd0, fill_q, 3'b000};
					fill_q <= '0;
					widx_q <= fill_q[5:2] + ADDR_W'(1);
				end
				S_ZERO, S_LEN: widx_q <= widx_q + ADDR_W'(1);
				S_OUT: begin
					if (out_acc) begin
						oidx_q <= oidx_q + 3'd1;
						if (m_tlast) begin
							bits_q <= '0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	`SHA_ASSERT_IMPL(a_in_engine_idle, clk, arst_n, s_tready, !sts.busy)
	`SHA_ASSERT_IMPL(a_wr_engine_idle, clk, arst_n, wr.en, !sts.busy)
	`SHA_ASSERT_IMPL(a_done_in_comp, clk, arst_n, sts.done, st_q == S_COMP)
	`SHA_ASSERT_NEXT(a_clean_restart, clk, arst_n, out_acc && m_tlast, (st_q == S_IN) && (bits_q == '0) && (fill_q == '0))

endmodule

/* tb/sha256_stream_hasher_tb.sv */
// Self-checking testbench for the SHA-256 stream hasher: byte beats in, digest words out.
// A behavioral SHA-256 model predicts every digest word. Needs the RTL of sha256_stream_hasher,
// sha_comp, sha_blkmem, sha_pkg and the assertion macros header.
module sha256_stream_hasher_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RX_HOLD_CYCLES = 400;
	localparam int SETTLE_CYCLES  = 200;

	localparam logic [31:0] K_ROUND [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] IV_WORDS [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	typedef struct {
		logic [31:0] word;
		logic [2:0]  pos;
		logic        is_last;
	} digest_beat_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [7:0] data_byte
	logic        s_tuser;   // [0] byte_valid
	logic        s_tlast;   // end_of_message
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;   // [31:0] digest_word, [34:32] word_index, rest zero
	logic        m_tlast;   // last_word

	// Hash model state.
	logic [31:0] chain_words [8];
	logic [7:0]  block_bytes [64];
	int unsigned block_fill;
	logic [63:0] bits_done;

	digest_beat_t digest_words_due [$];
	int           mismatch_count = 0;
	int           beats_sent = 0;
	int           tx_idle_pct = 0;
	int           rx_stall_pct = 0;
	logic         hold_toggle = 1'b0;

	sha256_stream_hasher dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Run limit, far above the slowest legal run.
	initial begin
		#2_000_000;
		$display("TB_ERROR");
		$finish;
	end

	function automatic logic [31:0] rotr(logic [31:0] x, int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic void restart_chain();
		for (int i = 0; i < 8; i++)
			chain_words[i] = IV_WORDS[i];
		block_fill = 0;
		bits_done  = '0;
	endfunction

	// One 64-round compression of block_bytes into chain_words.
	function automatic void compress_block_bytes();
		logic [31:0] w [64];
		logic [31:0] v [8];
		logic [31:0] s0, s1, t1, t2;
		for (int i = 0; i < 16; i++)
			w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2],
				block_bytes[4*i+3]};
		for (int i = 16; i < 64; i++) begin
			s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
			s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
			w[i] = s1 + w[i-7] + s0 + w[i-16];
		end
		for (int i = 0; i < 8; i++)
			v[i] = chain_words[i];
		for (int i = 0; i < 64; i++) begin
			t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25)) +
				((v[4] & v[5]) ^ (~v[4] & v[6])) + K_ROUND[i] + w[i];
			t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22)) +
				((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6];
			v[6] = v[5];
			v[5] = v[4];
			v[4] = v[3] + t1;
			v[3] = v[2];
			v[2] = v[1];
			v[1] = v[0];
			v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++)
			chain_words[i] += v[i];
	endfunction

	// Absorb one accepted input beat; on end of message, pad and queue the digest.
	function automatic void absorb_byte_beat(logic [7:0] b, logic v, logic eom);
		logic [63:0]  total;
		digest_beat_t beat;
		if (v) begin
			block_bytes[block_fill] = b;
			block_fill++;
			if (block_fill == 64) begin
				compress_block_bytes();
				bits_done  += 64'd512;
				block_fill = 0;
			end
		end
		if (eom) begin
			total = bits_done + 64'(block_fill) * 64'd8;
			block_bytes[block_fill] = 8'h80;
			block_fill++;
			// No room for the length field: finish this block with zeros first.
			if (block_fill > 56) begin
				while (block_fill < 64) begin
					block_bytes[block_fill] = 8'h00;
					block_fill++;
				end
				compress_block_bytes();
				block_fill = 0;
			end
			while (block_fill < 56) begin
				block_bytes[block_fill] = 8'h00;
				block_fill++;
			end
			for (int i = 0; i < 8; i++)
				block_bytes[56 + i] = total[63 - 8*i -: 8];
			compress_block_bytes();
			for (int i = 0; i < 8; i++) begin
				beat.word    = chain_words[i];
				beat.pos     = 3'(i);
				beat.is_last = (i == 7);
				digest_words_due.push_back(beat);
			end
			restart_chain();
		end
	endfunction

	// Compare one digest beat taken from the block with the oldest expected word.
	function automatic void check_digest_beat();
		digest_beat_t want;
		if (digest_words_due.size() == 0) begin
			$display("%0t: unexpected digest beat, expected none, actual word %h index %0d last %b",
				$time, m_tdata[31:0], m_tdata[34:32], m_tlast);
			mismatch_count++;
		end else begin
			want = digest_words_due.pop_front();
			if (m_tdata[31:0] !== want.word) begin
				$display("%0t: digest word mismatch, expected %h actual %h",
					$time, want.word, m_tdata[31:0]);
				mismatch_count++;
			end
			if (m_tdata[34:32] !== want.pos) begin
				$display("%0t: word index mismatch, expected %0d actual %0d",
					$time, want.pos, m_tdata[34:32]);
				mismatch_count++;
			end
			if (m_tlast !== want.is_last) begin
				$display("%0t: last word flag mismatch, expected %b actual %b",
					$time, want.is_last, m_tlast);
				mismatch_count++;
			end
		end
	endfunction

	// Digest receiver: checks each beat, stalls at random and on request holds off.
	initial begin
		int   hold_left;
		logic hold_seen;
		hold_left = 0;
		hold_seen = 1'b0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready)
				check_digest_beat();
			if (hold_toggle != hold_seen) begin
				hold_seen = hold_toggle;
				hold_left = RX_HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= rx_stall_pct);
			end
		end
	end

	// Offer one beat, with random idle cycles ahead of it, and wait until it is taken.
	task automatic send_beat(input logic [7:0] b, input logic v, input logic eom);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tuser  <= v;
		s_tlast  <= eom;
		do @(posedge clk); while (!s_tready);
		absorb_byte_beat(b, v, eom);
		if (v || eom)
			beats_sent++;
	endtask

	// A message of random bytes; the end flag rides on the last byte or on its own beat.
	task automatic send_message(input int len, input bit end_on_byte, input int noise_pct);
		for (int n = 0; n < len; n++) begin
			if ($urandom_range(99) < noise_pct)
				send_beat(8'($urandom_range(255)), 1'b0, 1'b0);
			send_beat(8'($urandom_range(255)), 1'b1, end_on_byte && (n == len - 1));
		end
		if (!end_on_byte || len == 0)
			send_beat(8'($urandom_range(255)), 1'b0, 1'b1);
	endtask

	task automatic stop_sending();
		s_tvalid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (digest_words_due.size() != 0)
			@(posedge clk);
	endtask

	// Extremes of the byte, idle beats, empty messages and both ways to end a message.
	task automatic test_directed_cases();
		tx_idle_pct = 0;
		rx_stall_pct <= 0;
		send_beat(8'hA5, 1'b0, 1'b0);
		send_beat(8'h3C, 1'b0, 1'b1);
		send_beat(8'h00, 1'b1, 1'b1);
		send_beat(8'hFF, 1'b1, 1'b0);
		send_beat(8'h5A, 1'b0, 1'b1);
		send_beat(8'h80, 1'b1, 1'b0);
		send_beat(8'hC3, 1'b0, 1'b0);
		send_beat(8'h7F, 1'b1, 1'b0);
		send_beat(8'h01, 1'b1, 1'b1);
		send_beat(8'hFF, 1'b0, 1'b0);
		send_beat(8'hFF, 1'b0, 1'b1);
		send_beat(8'h00, 1'b0, 1'b1);
		stop_sending();
		wait_drained();
	endtask

	// Lengths around the one- and two-block padding split and a full block.
	task automatic test_padding_boundaries();
		tx_idle_pct = 54;
		rx_stall_pct <= 0;
		send_message(55, 1'b1, 0);
		send_message(56, 1'b0, 0);
		send_message(63, 1'b1, 0);
		send_message(64, 1'b0, 0);
		stop_sending();
		wait_drained();
	endtask

	// Mostly short messages, a few spanning more blocks, with idle beats mixed in.
	task automatic test_random_messages(input int tx_pct, input int rx_pct, input int budget);
		int start;
		int len;
		start = beats_sent;
		tx_idle_pct = tx_pct;
		rx_stall_pct <= rx_pct;
		while (beats_sent - start < budget) begin
			if ($urandom_range(7) == 0)
				len = $urandom_range(100, 65);
			else
				len = $urandom_range(12, 0);
			send_message(len, 1'($urandom_range(1)), 10);
		end
		stop_sending();
		wait_drained();
	endtask

	// Long digest hold-off while messages keep coming, so the input backs up.
	task automatic test_output_backpressure();
		tx_idle_pct = 0;
		rx_stall_pct <= 0;
		hold_toggle <= ~hold_toggle;
		send_message(3, 1'b1, 0);
		send_message(0, 1'b0, 0);
		send_message(5, 1'b0, 0);
		send_message(2, 1'b1, 0);
		stop_sending();
		wait_drained();
	endtask

	initial begin
		restart_chain();
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= 8'h00;
		s_tuser  <= 1'b0;
		s_tlast  <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_padding_boundaries();
		test_random_messages(0, 0, 30);
		test_random_messages(54, 0, 30);
		test_random_messages(0, 54, 30);
		test_random_messages(28, 28, 30);
		test_output_backpressure();

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && digest_words_due.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
